### sv/double_ended_priority_queue_unit_assert.svh
// Assertion macros for the double-ended priority queue unit.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DEPQ_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define DEPQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define DEPQ_ASSERT_IMP(label, clk, rst, a, c)
`define DEPQ_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### sv/depq_pkg.sv
// Shared types and codes of the double-ended priority queue unit.
package depq_pkg;
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_POP_MAX = 2'd1;
  localparam logic [1:0] OP_POP_MIN = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam int EntryW = 63;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_OUT
  } state_t;
endpackage

### sv/depq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module depq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/double_ended_priority_queue_unit.sv
// Double-ended priority queue unit: top level.
// Entries (id, priority) live in one RAM in insertion order, oldest first.
// An insert is taken and gives no item unless the store is full, in which
// case one item with status full is presented on the next cycle. A pop
// streams the stored entries through the RAM read port, one per cycle, to
// find the highest (oldest on ties) or lowest (newest on ties) priority, then
// closes the gap by moving every later entry down one place, with a read
// state (S_SHIFT_RD) and a write state (S_SHIFT_WR) per moved entry. The
// result item of a pop is set into the output register in state S_OUT.
// A pop on an empty store presents status empty on the next cycle. The
// input is not ready while a result item waits in the output register, so
// the next item is taken only once that result item has been accepted.
// Operation code 3 is taken and ignored.
`include "double_ended_priority_queue_unit_assert.svh"
module double_ended_priority_queue_unit
  import depq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // operation[1:0], entry_id[32:2], entry_priority[64:33]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // status[1:0], out_id[32:2], out_priority[64:33]
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;       // scan position (the shift uses best)
  logic [AW-1:0] best;
  logic [31:0]   best_key;
  logic [62:0]   best_ent;
  logic          op_max;
  logic          out_v;
  logic [64:0]   out_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [62:0]   wdata, rdata;

  depq_ram #(.Width(EntryW), .Depth(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  wire [1:0]  in_op   = s_tdata[1:0];
  wire        s_acc   = s_tvalid && s_tready;
  wire [31:0] rd_key  = rdata[62:31] ^ 32'h8000_0000;
  wire [CW-1:0] prev  = idx - CW'(1);

  assign s_tready = (state == S_IDLE) && !out_v;
  assign m_tvalid = out_v;
  assign m_tdata  = {7'd0, out_d};

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:
        if (s_acc && (in_op == OP_POP_MAX || in_op == OP_POP_MIN) && count != '0)
          state_next = S_SCAN;
      S_SCAN:
        if (idx == count) state_next = S_SHIFT_RD;
      S_SHIFT_RD:
        state_next = (CW'(best) + CW'(1) >= count) ? S_OUT : S_SHIFT_WR;
      S_SHIFT_WR:
        state_next = S_SHIFT_RD;
      S_OUT:
        state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM port control.
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = s_tdata[64:2];
    raddr = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        we    = s_acc && in_op == OP_INSERT && count < CW'(CAPACITY);
        raddr = '0;
      end
      S_SHIFT_RD: raddr = AW'(CW'(best) + CW'(1));
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = best;
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: if (s_acc) begin
          op_max <= (in_op == OP_POP_MAX);
          idx    <= CW'(1);
          if (in_op == OP_INSERT) begin
            if (count < CW'(CAPACITY)) count <= count + CW'(1);
            else begin out_v <= 1'b1; out_d <= {63'd0, ST_FULL}; end
          end else if (in_op == OP_POP_MAX || in_op == OP_POP_MIN) begin
            if (count == '0) begin out_v <= 1'b1; out_d <= {63'd0, ST_EMPTY}; end
          end
        end
        S_SCAN: begin
          // rdata holds entry prev.
          if (prev == '0 || (op_max ? rd_key > best_key : rd_key <= best_key)) begin
            best     <= prev[AW-1:0];
            best_key <= rd_key;
            best_ent <= rdata;
          end
          if (idx != count) idx <= idx + CW'(1);
        end
        S_SHIFT_WR: best <= best + AW'(1);
        S_OUT: begin
          count <= count - CW'(1);
          out_v <= 1'b1;
          out_d <= {best_ent, ST_OK};
        end
        default: ;
      endcase
    end
  end

  `DEPQ_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !s_tready)
  `DEPQ_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `DEPQ_ASSERT_NEXT(a_out_after_pop, clk, rst, state == S_OUT, out_v && out_d[1:0] == ST_OK)
endmodule

### test/tb_double_ended_priority_queue_unit.sv
// Testbench of the double-ended priority queue unit with a built-in predictor.
module tb_double_ended_priority_queue_unit
  import depq_pkg::*;
();

  localparam int Capacity = 1024;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic [30:0] id;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0] status;
    logic [30:0] id;
    logic signed [31:0] prio;
  } result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [71:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [71:0] m_tdata;

  entry_t queue_contents[$];
  result_t pending_results[$];
  int error_count;
  int cycle_count;
  bit idle_enable;

  double_ended_priority_queue_unit #(.CAPACITY(Capacity)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one accepted item to the mirrored contents and queues what it returns.
  task automatic apply_item(input logic [1:0] op, input logic [30:0] id,
                            input logic signed [31:0] prio);
    result_t r;
    int pick;
    entry_t e;
    begin
      r = '0;
      if (op == OP_INSERT) begin
        if (queue_contents.size() >= Capacity) begin
          r.status = ST_FULL;
          pending_results.push_back(r);
        end else begin
          e.id = id;
          e.prio = prio;
          queue_contents.push_back(e);
        end
      end else if (op == OP_POP_MAX || op == OP_POP_MIN) begin
        if (queue_contents.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pick = 0;
          for (int i = 1; i < queue_contents.size(); i++) begin
            // Highest keeps the oldest on ties, lowest takes the newest.
            if (op == OP_POP_MAX && queue_contents[i].prio > queue_contents[pick].prio)
              pick = i;
            if (op == OP_POP_MIN && queue_contents[i].prio <= queue_contents[pick].prio)
              pick = i;
          end
          r.status = ST_OK;
          r.id = queue_contents[pick].id;
          r.prio = queue_contents[pick].prio;
          queue_contents.delete(pick);
        end
        pending_results.push_back(r);
      end
    end
  endtask

  // Sends one item; entered and left at a rising edge.
  task automatic send_item(input logic [1:0] op, input logic [30:0] id,
                           input logic signed [31:0] prio);
    int gap;
    begin
      if (idle_enable && $urandom_range(0, 99) < 33) begin
        gap = $urandom_range(1, 4);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= {7'b0, prio, id, op};
      do @(posedge clk); while (!s_tready);
      apply_item(op, id, prio);
    end
  endtask

  task automatic wait_drained;
    begin
      s_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      repeat (60) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] random_priority();
    int sel;
    begin
      sel = $urandom_range(0, 9);
      if (sel < 4) return $signed($urandom_range(0, 6)) - 3;
      if (sel == 4) return 32'sh8000_0000;
      if (sel == 5) return 32'sh7fff_ffff;
      return $urandom;
    end
  endfunction

  task automatic test_empty_pops;
    begin
      send_item(OP_POP_MAX, 31'h1234, 32'sd5);
      send_item(OP_POP_MIN, 31'h7fff_ffff, -32'sd1);
      send_item(OP_IGNORED, 31'h55, 32'sd9);  // unused code, no item back
      send_item(OP_POP_MIN, '0, '0);
      wait_drained();
    end
  endtask

  task automatic test_extremes_and_ties;
    begin
      send_item(OP_INSERT, 31'h0, 32'sh8000_0000);
      send_item(OP_INSERT, 31'h7fff_ffff, 32'sh7fff_ffff);
      send_item(OP_INSERT, 31'h1, 32'sd7);
      send_item(OP_INSERT, 31'h2, 32'sd7);
      send_item(OP_INSERT, 31'h3, 32'sd7);
      send_item(OP_INSERT, 31'h4, 32'sh8000_0000);
      send_item(OP_POP_MAX, '0, '0);
      send_item(OP_POP_MAX, '0, '0);
      send_item(OP_POP_MIN, '0, '0);
      send_item(OP_POP_MIN, '0, '0);
      send_item(OP_POP_MIN, '0, '0);
      send_item(OP_POP_MAX, '0, '0);
      send_item(OP_POP_MAX, '0, '0);
      send_item(OP_POP_MIN, '0, '0);
      wait_drained();
    end
  endtask

  task automatic test_random_mix;
    int roll;
    logic [1:0] op;
    begin
      for (int n = 0; n < 60; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) op = OP_IGNORED;
        else if (queue_contents.size() < 6) op = (roll < 75) ? OP_INSERT : OP_POP_MAX;
        else if (queue_contents.size() > 40) op = (roll < 30) ? OP_INSERT : OP_POP_MIN;
        else op = (roll < 52) ? OP_INSERT : ((roll & 1) ? OP_POP_MAX : OP_POP_MIN);
        if (op == OP_POP_MIN && roll[2]) op = OP_POP_MAX;
        send_item(op, 31'($urandom), random_priority());
      end
      wait_drained();
    end
  endtask

  task automatic test_fill_to_capacity;
    begin
      while (queue_contents.size() < Capacity) begin
        // One long stretch with no idling on either side.
        idle_enable = !(queue_contents.size() >= 300 && queue_contents.size() < 600);
        send_item(OP_INSERT, 31'($urandom), random_priority());
      end
      idle_enable = 1'b1;
      send_item(OP_INSERT, 31'h7fff_ffff, 32'sh7fff_ffff);
      send_item(OP_INSERT, 31'h0, 32'sh8000_0000);
      send_item(OP_POP_MIN, '0, '0);
      send_item(OP_INSERT, 31'h42, 32'sd0);
      send_item(OP_INSERT, 31'h43, 32'sd0);
      send_item(OP_POP_MAX, '0, '0);
      wait_drained();
    end
  endtask

  // Result checker: every accepted result must match the oldest expectation.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[1:0];
      got.id = m_tdata[32:2];
      got.prio = m_tdata[64:33];
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d id=%0h prio=%0d", got.status, got.id, got.prio);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          error_count++;
        end
        if (got.id !== want.id) begin
          $error("out_id expected %0h actual %0h", want.id, got.id);
          error_count++;
        end
        if (got.prio !== want.prio) begin
          $error("out_priority expected %0d actual %0d", want.prio, got.prio);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= idle_enable ? ($urandom_range(0, 99) >= 33) : 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("double_ended_priority_queue_unit test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    idle_enable = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pops();
    test_extremes_and_ties();
    test_random_mix();
    test_fill_to_capacity();
    if (error_count == 0) begin
      $display("double_ended_priority_queue_unit test passed");
    end else begin
      $display("double_ended_priority_queue_unit test failed");
    end
    $finish;
  end
endmodule
